// ===== hdl/hrp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrp_pkg
// Types, pattern texts and matcher functions for the request header parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

    localparam int NumPat     = 7;   // six header names plus the terminator
    localparam int PatTerm    = 6;
    localparam int PatMaxLen  = 20;
    localparam int ProgW      = 5;

    localparam logic [7:0]  MethodLimitRst = 8'd15;
    localparam logic [11:0] PathLimitRst   = 12'd1023;
    localparam logic [11:0] QueryLimitRst  = 12'd1023;
    localparam logic [19:0] HeaderLimitRst = 20'd65535;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 20;
    localparam logic [CfgIdxW-1:0] CfgMethodLimit = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgPathLimit   = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgQueryLimit  = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgHeaderLimit = 2'd3;

    localparam logic [1:0] KindOther  = 2'd0;
    localparam logic [1:0] KindMethod = 2'd1;
    localparam logic [1:0] KindPath   = 2'd2;
    localparam logic [1:0] KindQuery  = 2'd3;

    localparam logic [1:0] StatusOk      = 2'd0;
    localparam logic [1:0] StatusBadLine = 2'd1;
    localparam logic [1:0] StatusTooLong = 2'd2;

    // texts right-aligned: first character in the highest used byte
    localparam logic [8*PatMaxLen-1:0] PAT_TEXT [NumPat] = '{
        "Content-Length:", "content-length:",
        "Transfer-Encoding:", "transfer-encoding:",
        "Expect: 100-continue", "expect: 100-continue",
        "\r\n\r\n"
    };
    localparam int PAT_LEN [NumPat] = '{15, 15, 18, 18, 20, 20, 4};

    localparam logic [55:0] CHUNK_TEXT = "chunked";
    localparam logic [31:0] POST_TEXT  = "POST";

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } hrp_in_t;

    typedef struct packed {
        logic [7:0]         char_out;
        logic [1:0]         char_kind;
        logic               header_end;
        logic [1:0]         parse_status;
        logic signed [31:0] body_length;
        logic               chunked;
        logic               expect_continue;
    } hrp_out_t;

    function automatic logic [7:0] pat_byte(int p, int i);
        return PAT_TEXT[p][8*(PAT_LEN[p]-1-i) +: 8];
    endfunction

    // pattern prefix of j-1 bytes equals the bytes just before position k
    function automatic logic pat_border(int p, int k, int j);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < j - 1; i++) begin
            if (pat_byte(p, i) != pat_byte(p, k + 1 - j + i)) ok = 1'b0;
        end
        return ok;
    endfunction

    // longest pattern prefix ending the text after k matched bytes and c
    function automatic logic [ProgW-1:0] pat_adv(int p, logic [ProgW-1:0] k,
                                                 logic [7:0] c);
        logic [ProgW-1:0] r;
        r = '0;
        for (int kk = 0; kk < PAT_LEN[p]; kk++) begin
            if (k == ProgW'(kk)) begin
                for (int j = 1; j <= kk + 1; j++) begin
                    if (pat_border(p, kk, j) && c == pat_byte(p, j - 1))
                        r = ProgW'(j);
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/http_request_header_parser.sv =====
// ----------------------------------------------------------------------------
// http_request_header_parser
// Tags request header bytes and extracts length, chunked and expect info.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one header byte per item plus first_byte, which
//   clears all parse state before that byte is processed. Each accepted
//   item gives exactly one result item on the m_ channel: the byte, its
//   kind, and on the terminating or overflowing byte the status, on a clean
//   end also the Content-Length / chunked / expect summary.
//   The result is loaded into the output register at the accepting edge
//   and can be taken from the next edge on. Throughput is one item per
//   cycle while the receiver keeps up; the matchers and counters all update
//   in the same cycle as the byte.
//   s_ready is high whenever the output register is empty or being taken,
//   so a stalled receiver holds back the input only for as long as it stalls.
//   Limits are written through cfg_we/cfg_index/cfg_data while idle; the
//   user must keep to this, the block does not check it. Reset restores
//   the default limits and clears all parse state.
// ----------------------------------------------------------------------------
module http_request_header_parser import hrp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hrp_in_t             s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hrp_out_t            m_data,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    typedef enum logic [2:0] {
        PH_METHOD, PH_PATH, PH_QUERY, PH_HEADERS, PH_DONE
    } phase_t;

    logic [7:0]  method_limit_reg;
    logic [11:0] path_limit_reg, query_limit_reg;
    logic [19:0] header_limit_reg;

    phase_t             phase_reg, phase_next;
    logic [7:0]         mcnt_reg, mcnt_next;
    logic [11:0]        pcnt_reg, pcnt_next, qcnt_reg, qcnt_next;
    logic [19:0]        hcnt_reg, hcnt_next;
    logic [2:0]         post_reg, post_next;
    logic [ProgW-1:0]   prog_reg [NumPat];
    logic [ProgW-1:0]   prog_next [NumPat];
    logic [ProgW-1:0]   prog_cur [NumPat];
    logic [ProgW-1:0]   prog_adv [NumPat];
    logic signed [31:0] lval_reg [2];
    logic signed [31:0] lval_next [2];
    logic [2:0]         lst_reg [2];
    logic [2:0]         lst_next [2];
    logic [3:0]         cst_reg [2];
    logic [3:0]         cst_next [2];
    logic [1:0]         cfound_reg, cfound_next;
    logic               efound_reg, efound_next;
    logic               err_reg, err_next;

    logic     accept;
    hrp_out_t res;
    logic [7:0] c;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid || m_ready;
    assign c       = s_data.data_byte;

    for (genvar p = 0; p < NumPat; p++) begin : g_match
        assign prog_cur[p] = s_data.first_byte ? '0 : prog_reg[p];
        hrp_matcher #(.PAT(p)) u_match (
            .prog      (prog_cur[p]),
            .c         (c),
            .prog_next (prog_adv[p])
        );
    end

    always_comb begin
        logic               dig, ws, complete, ended;
        logic signed [35:0] t;
        logic [3:0]         d;
        logic [2:0]         k;
        phase_t             ph;

        dig = c >= "0" && c <= "9";
        ws  = c == " " || (c >= 8'd9 && c <= 8'd13);
        d   = c[3:0];
        t   = '0;
        k   = '0;

        if (s_data.first_byte) begin
            ph = PH_METHOD;
            mcnt_next = '0; pcnt_next = '0; qcnt_next = '0; hcnt_next = '0;
            post_next = '0;
            for (int i = 0; i < 2; i++) begin
                lval_next[i] = -32'sd1; lst_next[i] = '0; cst_next[i] = '0;
            end
            cfound_next = '0; efound_next = 1'b0; err_next = 1'b0;
        end else begin
            ph = phase_reg;
            mcnt_next = mcnt_reg; pcnt_next = pcnt_reg; qcnt_next = qcnt_reg;
            hcnt_next = hcnt_reg; post_next = post_reg;
            for (int i = 0; i < 2; i++) begin
                lval_next[i] = lval_reg[i]; lst_next[i] = lst_reg[i];
                cst_next[i] = cst_reg[i];
            end
            cfound_next = cfound_reg; efound_next = efound_reg; err_next = err_reg;
        end
        for (int p = 0; p < NumPat; p++) prog_next[p] = prog_cur[p];
        phase_next = ph;

        res = '0;
        res.char_out     = c;
        res.char_kind    = KindOther;
        res.parse_status = StatusOk;
        res.body_length  = -32'sd1;
        complete = 1'b0;
        ended    = 1'b0;

        if (ph != PH_DONE) begin
            if (hcnt_next != 20'hFFFFF) hcnt_next = hcnt_next + 20'd1;
            complete = prog_adv[PatTerm] == ProgW'(PAT_LEN[PatTerm]);
            prog_next[PatTerm] = complete ? '0 : prog_adv[PatTerm];

            // header names and their values; bit 0 of p picks the slot
            for (int p = 0; p < PatTerm; p++) begin
                if (prog_cur[p] >= ProgW'(PAT_LEN[p])) begin
                    if (p < 2) begin
                        case (lst_next[p[0]])
                            3'd1: begin
                                if (!ws) begin
                                    if (c == "+") lst_next[p[0]] = 3'd2;
                                    else if (c == "-") lst_next[p[0]] = 3'd3;
                                    else if (dig) begin
                                        lval_next[p[0]] = 32'(d);
                                        lst_next[p[0]] = 3'd4;
                                    end else lst_next[p[0]] = 3'd6;
                                end
                            end
                            3'd2, 3'd3: begin
                                if (dig) begin
                                    lval_next[p[0]] = (lst_next[p[0]] == 3'd2) ?
                                        32'(d) : -32'(d);
                                    lst_next[p[0]] = (lst_next[p[0]] == 3'd2) ?
                                        3'd4 : 3'd5;
                                end else lst_next[p[0]] = 3'd6;
                            end
                            3'd4, 3'd5: begin
                                if (!dig) lst_next[p[0]] = 3'd6;
                                else begin
                                    t = (36'(lval_next[p[0]]) <<< 3) +
                                        (36'(lval_next[p[0]]) <<< 1);
                                    if (lst_next[p[0]] == 3'd4) begin
                                        t = t + 36'(d);
                                        if (t > 36'sh07FFFFFFF) t = 36'sh07FFFFFFF;
                                    end else begin
                                        t = t - 36'(d);
                                        if (t < -36'sh080000000) t = -36'sh080000000;
                                    end
                                    lval_next[p[0]] = t[31:0];
                                end
                            end
                            default: ;
                        endcase
                    end else if (p < 4) begin
                        if (cst_next[p[0]] != 4'd0 && cst_next[p[0]] < 4'd9 &&
                            !(cst_next[p[0]] == 4'd1 && c == " ")) begin
                            k = (cst_next[p[0]] == 4'd1) ? 3'd0 :
                                3'(cst_next[p[0]] - 4'd2);
                            if (CHUNK_TEXT[8*(3'd6-k) +: 8] == c) begin
                                if (k == 3'd6) begin
                                    cfound_next[p[0]] = 1'b1; cst_next[p[0]] = 4'd9;
                                end else cst_next[p[0]] = 4'(k) + 4'd3;
                            end else cst_next[p[0]] = 4'd9;
                        end
                    end
                end else begin
                    prog_next[p] = prog_adv[p];
                    if (prog_adv[p] == ProgW'(PAT_LEN[p])) begin
                        if (p < 2) begin
                            lst_next[p[0]] = 3'd1; lval_next[p[0]] = '0;
                        end else if (p < 4) cst_next[p[0]] = 4'd1;
                        else efound_next = 1'b1;
                    end
                end
            end

            // request line tagging
            case (ph)
                PH_METHOD: begin
                    if (c == " ") begin
                        if (post_next != 3'd4) post_next = 3'd5;
                        phase_next = PH_PATH;
                    end else if (mcnt_next < method_limit_reg) begin
                        mcnt_next = mcnt_next + 8'd1;
                        res.char_kind = KindMethod;
                        if (post_next < 3'd4 &&
                            POST_TEXT[8*(3'd3-post_next) +: 8] == c)
                            post_next = post_next + 3'd1;
                        else post_next = 3'd5;
                    end else begin
                        err_next = 1'b1;
                        phase_next = PH_HEADERS;
                    end
                end
                PH_PATH: begin
                    if (c == " " || c == "\r") phase_next = PH_HEADERS;
                    else if (c == "?") phase_next = PH_QUERY;
                    else if (pcnt_next < path_limit_reg) begin
                        pcnt_next = pcnt_next + 12'd1; res.char_kind = KindPath;
                    end
                end
                PH_QUERY: begin
                    if (c == " " || c == "\r") phase_next = PH_HEADERS;
                    else if (qcnt_next < query_limit_reg) begin
                        qcnt_next = qcnt_next + 12'd1; res.char_kind = KindQuery;
                    end
                end
                default: ;
            endcase

            if (complete) begin
                ended = 1'b1;
                res.parse_status = (err_next || phase_next == PH_METHOD) ?
                    StatusBadLine : StatusOk;
            end else if (hcnt_next >= header_limit_reg) begin
                ended = 1'b1;
                res.parse_status = StatusTooLong;
            end
            if (ended) phase_next = PH_DONE;
            res.header_end = ended;
            if (ended && res.parse_status == StatusOk) begin
                if (prog_next[0] == ProgW'(PAT_LEN[0])) res.body_length = lval_next[0];
                else if (prog_next[1] == ProgW'(PAT_LEN[1]))
                    res.body_length = lval_next[1];
                if (prog_next[2] == ProgW'(PAT_LEN[2])) res.chunked = cfound_next[0];
                else if (prog_next[3] == ProgW'(PAT_LEN[3])) res.chunked = cfound_next[1];
                res.expect_continue = post_next == 3'd4 && efound_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_limit_reg <= MethodLimitRst;
            path_limit_reg   <= PathLimitRst;
            query_limit_reg  <= QueryLimitRst;
            header_limit_reg <= HeaderLimitRst;
            phase_reg  <= PH_METHOD;
            mcnt_reg   <= '0;
            pcnt_reg   <= '0;
            qcnt_reg   <= '0;
            hcnt_reg   <= '0;
            post_reg   <= '0;
            for (int p = 0; p < NumPat; p++) prog_reg[p] <= '0;
            for (int i = 0; i < 2; i++) begin
                lval_reg[i] <= -32'sd1;
                lst_reg[i]  <= '0;
                cst_reg[i]  <= '0;
            end
            cfound_reg <= '0;
            efound_reg <= 1'b0;
            err_reg    <= 1'b0;
            m_valid    <= 1'b0;
            m_data     <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CfgMethodLimit: method_limit_reg <= cfg_data[7:0];
                    CfgPathLimit:   path_limit_reg   <= cfg_data[11:0];
                    CfgQueryLimit:  query_limit_reg  <= cfg_data[11:0];
                    CfgHeaderLimit: header_limit_reg <= cfg_data[19:0];
                    default: ;
                endcase
            end
            if (accept) begin
                phase_reg  <= phase_next;
                mcnt_reg   <= mcnt_next;
                pcnt_reg   <= pcnt_next;
                qcnt_reg   <= qcnt_next;
                hcnt_reg   <= hcnt_next;
                post_reg   <= post_next;
                prog_reg   <= prog_next;
                lval_reg   <= lval_next;
                lst_reg    <= lst_next;
                cst_reg    <= cst_next;
                cfound_reg <= cfound_next;
                efound_reg <= efound_next;
                err_reg    <= err_next;
                m_valid    <= 1'b1;
                m_data     <= res;
            end else if (m_ready) begin
                m_valid    <= 1'b0;
            end
        end
    end

    // status only on the closing item
    a_status_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.header_end |-> m_data.parse_status == StatusOk)
        else $error("status without header end");

    // no summary fields on a failed end
    a_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.parse_status != StatusOk |->
            m_data.body_length == -32'sd1 && !m_data.chunked &&
            !m_data.expect_continue)
        else $error("summary on failed header");

    // a stalled result is not overwritten
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result lost under stall");

endmodule

// ===== hdl/hrp_matcher.sv =====
// ----------------------------------------------------------------------------
// hrp_matcher
// Next-state logic of one substring matcher (prefix automaton).
// ----------------------------------------------------------------------------
module hrp_matcher import hrp_pkg::*; #(
    parameter int PAT = 0
) (
    input  logic [ProgW-1:0] prog,
    input  logic [7:0]       c,
    output logic [ProgW-1:0] prog_next
);

    assign prog_next = pat_adv(PAT, prog, c);

endmodule

// ===== tb/sv/http_request_header_parser_tb.sv =====
// ----------------------------------------------------------------------------
// http_request_header_parser_tb
// Self-checking bench: request headers, broken lines and noise are streamed
// byte by byte under random stalls, and each result item is compared with an
// in-bench model of the tagging, matching and summary logic.
// ----------------------------------------------------------------------------
module http_request_header_parser_tb import hrp_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 3000;
    localparam int HoldCycles = 400;

    typedef enum logic [2:0] {
        PH_METHOD, PH_PATH, PH_QUERY, PH_HEADERS, PH_DONE
    } phase_t;

    // length parser states
    localparam int LenIdle = 0, LenSkip = 1, LenPlus = 2, LenMinus = 3;
    localparam int LenPos = 4, LenNeg = 5, LenDone = 6;
    // chunk parser: 0 idle, 1 skip spaces, 3..8 letters matched, 9 done
    localparam int ChkIdle = 0, ChkSkip = 1, ChkDone = 9;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    hrp_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    hrp_out_t m_data;
    logic                cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    http_request_header_parser i_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data, .cfg_we, .cfg_index, .cfg_data
    );

    always #5 aclk = ~aclk;

    // ---------------- parser model ----------------
    string names [6] = '{"Content-Length:", "content-length:",
                         "Transfer-Encoding:", "transfer-encoding:",
                         "Expect: 100-continue", "expect: 100-continue"};
    string crlf2 = "\r\n\r\n";
    string chunk_word = "chunked";
    string post_word = "POST";

    logic [7:0]  lim_method;
    logic [11:0] lim_path, lim_query;
    logic [19:0] lim_header;

    phase_t      phase;
    int          n_method, n_path, n_query;
    logic [19:0] n_header;
    int          term_prog, post_prog;
    int          name_prog [6];
    int          len_val [2];
    int          len_st [2];
    int          chk_st [2];
    bit          chk_found [2];
    bit          exp_seen, bad_line;

    hrp_out_t results_due [$];

    function automatic void clear_request();
        phase = PH_METHOD;
        n_method = 0; n_path = 0; n_query = 0; n_header = '0;
        term_prog = 0; post_prog = 0;
        foreach (name_prog[p]) name_prog[p] = 0;
        len_val = '{-1, -1}; len_st = '{LenIdle, LenIdle};
        chk_st = '{ChkIdle, ChkIdle}; chk_found = '{0, 0};
        exp_seen = 0; bad_line = 0;
    endfunction

    // longest prefix of txt that ends the stream after k matched bytes and c
    function automatic int next_prog(string txt, int k, byte unsigned c);
        bit ok;
        for (int j = k + 1; j > 0; j--) begin
            ok = (txt[j-1] == c);
            for (int i = 0; i < j - 1 && ok; i++)
                if (txt[i] != txt[k + 1 - j + i]) ok = 0;
            if (ok) return j;
        end
        return 0;
    endfunction

    function automatic void length_byte(int i, byte unsigned c);
        bit     dig, ws;
        longint t;
        dig = c >= "0" && c <= "9";
        ws = c == " " || (c >= 9 && c <= 13);
        case (len_st[i])
            LenSkip: begin
                if (!ws) begin
                    if (c == "+") len_st[i] = LenPlus;
                    else if (c == "-") len_st[i] = LenMinus;
                    else if (dig) begin
                        len_val[i] = c - "0"; len_st[i] = LenPos;
                    end else len_st[i] = LenDone;
                end
            end
            LenPlus, LenMinus: begin
                if (dig) begin
                    len_val[i] = (len_st[i] == LenPlus) ? (c - "0") : -(c - "0");
                    len_st[i] = (len_st[i] == LenPlus) ? LenPos : LenNeg;
                end else len_st[i] = LenDone;
            end
            LenPos, LenNeg: begin
                if (!dig) len_st[i] = LenDone;
                else begin
                    if (len_st[i] == LenPos) begin
                        t = longint'(len_val[i]) * 10 + (c - "0");
                        if (t > 64'sd2147483647) t = 64'sd2147483647;
                    end else begin
                        t = longint'(len_val[i]) * 10 - (c - "0");
                        if (t < -64'sd2147483648) t = -64'sd2147483648;
                    end
                    len_val[i] = int'(t);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void chunk_byte(int i, byte unsigned c);
        int k;
        if (chk_st[i] == ChkIdle || chk_st[i] >= ChkDone) return;
        if (chk_st[i] == ChkSkip && c == " ") return;
        k = (chk_st[i] == ChkSkip) ? 0 : chk_st[i] - 2;
        if (chunk_word[k] == c) begin
            if (k == 6) begin
                chk_found[i] = 1; chk_st[i] = ChkDone;
            end else chk_st[i] = k + 3;
        end else chk_st[i] = ChkDone;
    endfunction

    function automatic void match_names(byte unsigned c);
        for (int p = 0; p < 6; p++) begin
            if (name_prog[p] >= names[p].len()) begin
                if (p < 2) length_byte(p, c);
                else if (p < 4) chunk_byte(p - 2, c);
            end else begin
                name_prog[p] = next_prog(names[p], name_prog[p], c);
                if (name_prog[p] == names[p].len()) begin
                    if (p < 2) begin
                        len_st[p] = LenSkip; len_val[p] = 0;
                    end else if (p < 4) chk_st[p-2] = ChkSkip;
                    else exp_seen = 1;
                end
            end
        end
    endfunction

    function automatic logic [1:0] tag_of(byte unsigned c);
        case (phase)
            PH_METHOD: begin
                if (c == " ") begin
                    if (post_prog != 4) post_prog = 5;
                    phase = PH_PATH;
                    return KindOther;
                end
                if (n_method < lim_method) begin
                    n_method++;
                    if (post_prog < 4 && post_word[post_prog] == c) post_prog++;
                    else post_prog = 5;
                    return KindMethod;
                end
                bad_line = 1;
                phase = PH_HEADERS;
                return KindOther;
            end
            PH_PATH: begin
                if (c == " " || c == "\r") begin
                    phase = PH_HEADERS; return KindOther;
                end
                if (c == "?") begin
                    phase = PH_QUERY; return KindOther;
                end
                if (n_path < lim_path) begin
                    n_path++; return KindPath;
                end
                return KindOther;
            end
            PH_QUERY: begin
                if (c == " " || c == "\r") begin
                    phase = PH_HEADERS; return KindOther;
                end
                if (n_query < lim_query) begin
                    n_query++; return KindQuery;
                end
                return KindOther;
            end
            default: return KindOther;
        endcase
    endfunction

    function automatic hrp_out_t parse_byte(hrp_in_t it);
        hrp_out_t    r;
        byte unsigned c;
        int          k;
        bit          complete;
        c = it.data_byte;
        r = '0;
        r.char_out = c;
        r.body_length = -1;
        if (it.first_byte) clear_request();
        if (phase != PH_DONE) begin
            if (n_header != 20'hFFFFF) n_header++;
            k = next_prog(crlf2, term_prog, c);
            complete = (k == 4);
            term_prog = complete ? 0 : k;
            match_names(c);
            r.char_kind = tag_of(c);
            if (complete) begin
                r.header_end = 1;
                r.parse_status = (bad_line || phase == PH_METHOD) ? StatusBadLine
                                                                  : StatusOk;
                phase = PH_DONE;
            end else if (n_header >= lim_header) begin
                r.header_end = 1;
                r.parse_status = StatusTooLong;
                phase = PH_DONE;
            end
            if (r.header_end && r.parse_status == StatusOk) begin
                if (name_prog[0] == names[0].len()) r.body_length = len_val[0];
                else if (name_prog[1] == names[1].len()) r.body_length = len_val[1];
                if (name_prog[2] == names[2].len()) r.chunked = chk_found[0];
                else if (name_prog[3] == names[3].len()) r.chunked = chk_found[1];
                r.expect_continue = (post_prog == 4) && exp_seen;
            end
        end
        return r;
    endfunction

    // ---------------- checking and watchdog ----------------
    int  errors = 0;
    int  quiet_cycles = 0;

    always @(negedge aclk) begin
        hrp_out_t w;
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
            $display("Some tests failed");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                $error("result item with none expected: %p", m_data);
                errors++;
            end else begin
                w = results_due.pop_front();
                if (m_data.char_out !== w.char_out) begin
                    $error("char_out exp %0h got %0h", w.char_out, m_data.char_out);
                    errors++;
                end
                if (m_data.char_kind !== w.char_kind) begin
                    $error("char_kind exp %0d got %0d", w.char_kind, m_data.char_kind);
                    errors++;
                end
                if (m_data.header_end !== w.header_end) begin
                    $error("header_end exp %0d got %0d", w.header_end, m_data.header_end);
                    errors++;
                end
                if (m_data.parse_status !== w.parse_status) begin
                    $error("parse_status exp %0d got %0d", w.parse_status,
                           m_data.parse_status);
                    errors++;
                end
                if (m_data.body_length !== w.body_length) begin
                    $error("body_length exp %0d got %0d", w.body_length,
                           m_data.body_length);
                    errors++;
                end
                if (m_data.chunked !== w.chunked) begin
                    $error("chunked exp %0d got %0d", w.chunked, m_data.chunked);
                    errors++;
                end
                if (m_data.expect_continue !== w.expect_continue) begin
                    $error("expect_continue exp %0d got %0d", w.expect_continue,
                           m_data.expect_continue);
                    errors++;
                end
            end
        end
    end

    // ---------------- receiver ----------------
    int rx_idle_pct = 0;
    int tx_idle_pct = 0;
    int rx_hold = 0;
    int rx_hold_req = 0;    // bumped by a test to start a long hold
    int rx_hold_ack = 0;

    always @(posedge aclk) begin
        if (rx_hold_ack != rx_hold_req) begin
            rx_hold_ack <= rx_hold_req;
            rx_hold <= HoldCycles;
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ---------------- sender ----------------
    // called and returns at a rising edge
    task automatic send_byte(byte unsigned b, bit first);
        hrp_in_t it;
        bit      taken;
        it.data_byte = b;
        it.first_byte = first;
        s_valid <= 1'b1;
        s_data <= it;
        taken = 0;
        while (!taken) begin
            @(negedge aclk);
            if (s_ready) begin
                results_due.push_back(parse_byte(it));
                taken = 1;
            end
            @(posedge aclk);
        end
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic send_text(string txt, bit garble);
        byte unsigned b;
        for (int i = 0; i < txt.len(); i++) begin
            b = txt[i];
            if (garble && $urandom_range(49) == 0) b = 8'($urandom);
            send_byte(b, i == 0);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_limit(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CfgMethodLimit: lim_method = val[7:0];
            CfgPathLimit:   lim_path = val[11:0];
            CfgQueryLimit:  lim_query = val[11:0];
            default:        lim_header = val;
        endcase
    endtask

    task automatic set_limits(int m, int p, int q, int h);
        drain();
        set_limit(CfgMethodLimit, CfgDataW'(m));
        set_limit(CfgPathLimit, CfgDataW'(p));
        set_limit(CfgQueryLimit, CfgDataW'(q));
        set_limit(CfgHeaderLimit, CfgDataW'(h));
    endtask

    function automatic string rand_word(int lo, int hi, string pool);
        string s = "";
        int    n = $urandom_range(hi, lo);
        for (int i = 0; i < n; i++)
            s = $sformatf("%s%c", s, pool[$urandom_range(pool.len() - 1)]);
        return s;
    endfunction

    function automatic string build_request();
        string s, v, tail;
        string methods [6] = '{"GET", "POST", "PUT", "POSTX", "PO", "DELETE"};
        string urlch = "abcxyz0129/._-=&%";
        s = ($urandom_range(5) == 0) ? rand_word(1, 20, "ABCDEFGHOPST")
                                     : methods[$urandom_range(5)];
        s = {s, " /", rand_word(0, 12, urlch)};
        if ($urandom_range(1)) s = {s, "?", rand_word(0, 12, urlch)};
        if ($urandom_range(3) == 0) tail = "\r\n";
        else tail = " HTTP/1.1\r\n";
        s = {s, tail};
        repeat ($urandom_range(4)) begin
            case ($urandom_range(7))
                0: begin
                    case ($urandom_range(5))
                        0: v = $sformatf("%0d", $urandom_range(100000));
                        1: v = "99999999999";
                        2: v = "-99999999999";
                        3: v = $sformatf("+%0d", $urandom_range(999));
                        4: v = $sformatf("-%0d", $urandom_range(999));
                        default: v = rand_word(0, 3, " \t+-x7");
                    endcase
                    s = {s, ($urandom_range(1) ? names[0] : names[1]),
                         rand_word(0, 2, " \t"), v, "\r\n"};
                end
                1: begin
                    if ($urandom_range(3) != 0) v = chunk_word;
                    else v = "chunkex";
                    s = {s, ($urandom_range(1) ? names[2] : names[3]),
                         rand_word(0, 2, " "), v, "\r\n"};
                end
                2: s = {s, ($urandom_range(1) ? names[4] : names[5]), "\r\n"};
                3: s = {s, "Content-Type: text\r\n"};
                4: s = {s, "Expect: 100-cont\r\n"};
                5: s = {s, "Transfer-Encoding:   chunked, gzip\r\n"};
                default: s = {s, "Host: ", rand_word(1, 10, urlch), "\r\n"};
            endcase
        end
        return {s, "\r\n"};
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed();
        send_text("POST /a?b\r\n\r\n", 0);
        send_text("GET\r\n\r\n", 0);
        send_byte(8'h00, 1);
        send_byte(8'hFF, 0);
        send_byte(8'h20, 0);
        send_text("\r\n\r\nzz", 0);   // bytes after the end stay other
    endtask

    task automatic test_requests(int n_items);
        int sent = 0;
        string s;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                // noise, occasionally restarting mid-stream
                repeat ($urandom_range(1, 8)) begin
                    send_byte(8'($urandom), $urandom_range(15) == 0);
                    sent++;
                end
            end else begin
                s = build_request();
                send_text(s, $urandom_range(3) == 0);
                sent += s.len();
            end
        end
    endtask

    task automatic test_limits();
        set_limits(1, 1, 1, 4);
        send_text("P /ab?cd\r\n\r\n", 0);
        send_text("GE /x\r\n\r\n", 0);
        send_text("A\r\n\r\n", 0);
        set_limits(3, 2, 2, 24);
        test_requests(150);
        set_limits(255, 4095, 4095, 1048575);
        send_text({rand_word(200, 260, "GPOST"), " /x\r\n\r\n"}, 0);
        test_requests(150);
        set_limits($urandom_range(1, 255), $urandom_range(1, 4095),
                   $urandom_range(1, 4095), $urandom_range(4, 200));
        test_requests(150);
        set_limits(int'(MethodLimitRst), int'(PathLimitRst), int'(QueryLimitRst),
                   int'(HeaderLimitRst));
    endtask

    task automatic test_backpressure();
        rx_hold_req++;
        test_requests(60);
        drain();
        test_requests(60);
    endtask

    initial begin
        lim_method = MethodLimitRst;
        lim_path = PathLimitRst;
        lim_query = QueryLimitRst;
        lim_header = HeaderLimitRst;
        clear_request();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 14; rx_idle_pct = 80;
        test_directed();
        test_requests(350);
        tx_idle_pct = 80; rx_idle_pct = 14;
        test_limits();
        tx_idle_pct = 0; rx_idle_pct = 0;
        test_backpressure();
        test_requests(300);
        drain();

        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
